### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the checker modules
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MGCR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MGCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mgcr_pkg.sv
// ---------------------------------------------------------------------------
// mgcr_pkg
// types and constants shared by the move group conflict resolver
// ---------------------------------------------------------------------------
`default_nettype none
package mgcr_pkg;

  localparam logic [63:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;
  localparam int unsigned EPOCH_W   = 8;
  localparam int unsigned HASH_W    = 32;

  typedef struct packed {
    logic [63:0]        node_id;
    logic signed [31:0] move_gain;
    logic               last_in_group;
    logic               first_of_batch;
  } in_item_t;

  typedef struct packed {
    logic [63:0]        out_node;
    logic signed [31:0] out_gain;
    logic               accepted;
    logic               group_end;
    logic               overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_SUM,
    F_REC,
    F_QUO,
    F_MOD,
    F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_LK_RD,
    B_LK_CHK,
    B_BUF,
    B_IN_RD,
    B_IN_LD,
    B_IN_PR,
    B_IN_CHK,
    B_EM_RD,
    B_EM_OUT
  } back_state_e;

endpackage
`default_nettype wire

### hdl/mgcr_front.sv
// ---------------------------------------------------------------------------
// mgcr_front
// accepts moves and computes the home slot of each node in the moved-node set
// ---------------------------------------------------------------------------
`default_nettype none
module mgcr_front #(
  parameter int unsigned SET_DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              busy_o,
  input  mgcr_pkg::in_item_t in_item_i,
  output logic              q_push_o,
  input  logic              q_full_i,
  output mgcr_pkg::in_item_t q_item_o,
  output logic [((SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1)-1:0] q_slot_o
);
  import mgcr_pkg::*;

  localparam int unsigned SW   = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int unsigned Q_SH = SW - 1;
  // reciprocal so that q = (t + ((x - t) >> 1)) >> (SW - 1) with t = hi(x * REC_M)
  localparam logic [63:0] REC_FULL = ((64'd1 << (HASH_W + SW)) / 64'(SET_DEPTH))
                                     - (64'd1 << HASH_W) + 64'd1;
  localparam logic [HASH_W-1:0] REC_M  = REC_FULL[HASH_W-1:0];
  localparam logic [SW-1:0]     DEP_LO = SW'(SET_DEPTH);

  front_state_e        state_q, state_d;
  in_item_t            item_q, item_d;
  logic [63:0]         pp_ll_q, pp_ll_d;
  logic [31:0]         pp_a_q, pp_a_d, pp_b_q, pp_b_d;
  logic [HASH_W-1:0]   word_q, word_d;
  logic [2*HASH_W-1:0] prod_q, prod_d;
  logic [HASH_W-1:0]   quo_q, quo_d;
  logic [HASH_W-1:0]   rec_hi;
  logic [SW-1:0]       rem_q, rem_d;

  assign rec_hi = prod_q[2*HASH_W-1:HASH_W];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (push_i) state_d = F_MUL;
      F_MUL:  state_d = F_SUM;
      F_SUM:  state_d = F_REC;
      F_REC:  state_d = F_QUO;
      F_QUO:  state_d = F_MOD;
      F_MOD:  state_d = F_PUSH;
      F_PUSH: if (!q_full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    item_d  = item_q;
    pp_ll_d = pp_ll_q;
    pp_a_d  = pp_a_q;
    pp_b_d  = pp_b_q;
    word_d  = word_q;
    prod_d  = prod_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    unique case (state_q)
      F_IDLE: if (push_i) item_d = in_item_i;
      F_MUL: begin
        // low 64 bits of the product are all the hash needs
        pp_ll_d = item_q.node_id[31:0] * HASH_MULT[31:0];
        pp_a_d  = item_q.node_id[31:0] * HASH_MULT[63:32];
        pp_b_d  = item_q.node_id[63:32] * HASH_MULT[31:0];
      end
      F_SUM: word_d = pp_ll_q[63:32] + pp_a_q + pp_b_q;
      F_REC: prod_d = word_q * REC_M;
      F_QUO: quo_d = (rec_hi + ((word_q - rec_hi) >> 1)) >> Q_SH;
      // remainder fits in SW bits, so only the low bits of q * depth matter
      F_MOD: rem_d = word_q[SW-1:0] - quo_q[SW-1:0] * DEP_LO;
      F_PUSH: ;
      default: ;
    endcase
  end

  assign busy_o   = (state_q != F_IDLE);
  assign q_push_o = (state_q == F_PUSH) && !q_full_i;
  assign q_item_o = item_q;
  assign q_slot_o = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    pp_ll_q <= pp_ll_d;
    pp_a_q  <= pp_a_d;
    pp_b_q  <= pp_b_d;
    word_q  <= word_d;
    prod_q  <= prod_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
  end

endmodule
`default_nettype wire

### hdl/mgcr_queue.sv
// ---------------------------------------------------------------------------
// mgcr_queue
// short fifo between the hashing front and the set back end
// ---------------------------------------------------------------------------
`default_nettype none
module mgcr_queue #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic [DW-1:0] data_o,
  output logic          empty_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FW = $clog2(DEPTH + 1);

  logic [DW-1:0] store_q [DEPTH];
  logic [AW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [FW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == FW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (do_push && !do_pop) cnt_d = cnt_q + FW'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - FW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) store_q[wptr_q] <= data_i;
  end

endmodule
`default_nettype wire

### hdl/mgcr_back.sv
// ---------------------------------------------------------------------------
// mgcr_back
// probes and fills the moved-node set, buffers each group and emits it
// ---------------------------------------------------------------------------
`default_nettype none
module mgcr_back #(
  parameter int unsigned SET_DEPTH = 1024,
  parameter int unsigned MAX_GROUP = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  output logic               q_pop_o,
  input  mgcr_pkg::in_item_t q_item_i,
  input  logic [((SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1)-1:0] q_slot_i,
  output logic               clear_busy_o,
  output logic               empty_o,
  input  logic               pop_i,
  output mgcr_pkg::out_item_t out_item_o
);
  import mgcr_pkg::*;

  localparam int unsigned SW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int unsigned GW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int unsigned FW = $clog2(MAX_GROUP + 1);
  localparam int unsigned KW = EPOCH_W + 64;
  localparam int unsigned BW = 96 + SW;

  back_state_e        state_q, state_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d, epoch_inc;
  logic [SW-1:0]      clr_q, clr_d;
  logic               pend_q, pend_d;
  logic [SW-1:0]      probe_q, probe_d, probe_nxt;
  logic [SW:0]        n_q, n_d, n_inc;
  logic [FW-1:0]      fill_q, fill_d, k_q, k_d, k_inc;
  logic               conflict_q, conflict_d, ovf_q, ovf_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;
  in_item_t           item_q, item_d;
  logic [SW-1:0]      slot_q, slot_d;
  logic [63:0]        ins_node_q, ins_node_d;

  logic [KW-1:0]      set_mem [SET_DEPTH];
  logic [KW-1:0]      set_rd_q, set_wd;
  logic [SW-1:0]      set_wa;
  logic               set_we;
  logic [BW-1:0]      buf_mem [MAX_GROUP];
  logic [BW-1:0]      buf_rd_q;
  logic               buf_we;

  logic               rd_live, lk_eq, in_eq, n_last, k_last, fill_ok, wrap, out_free;
  logic [63:0]        buf_node;
  logic [31:0]        buf_gain;
  logic [SW-1:0]      buf_slot;

  assign rd_live   = (set_rd_q[KW-1:64] == epoch_q);
  assign lk_eq     = (set_rd_q[63:0] == item_q.node_id);
  assign in_eq     = (set_rd_q[63:0] == ins_node_q);
  assign probe_nxt = (probe_q == SW'(SET_DEPTH - 1)) ? '0 : probe_q + SW'(1);
  assign n_inc     = n_q + (SW+1)'(1);
  assign n_last    = (n_inc == (SW+1)'(SET_DEPTH));
  assign k_inc     = k_q + FW'(1);
  assign k_last    = (k_inc == fill_q);
  assign fill_ok   = (fill_q < FW'(MAX_GROUP));
  assign epoch_inc = epoch_q + EPOCH_W'(1);
  assign wrap      = (epoch_inc == '0);
  assign out_free  = !out_valid_q || pop_i;
  assign buf_node  = buf_rd_q[BW-1:SW+32];
  assign buf_gain  = buf_rd_q[SW+31:SW];
  assign buf_slot  = buf_rd_q[SW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_CLEAR: if (clr_q == SW'(SET_DEPTH - 1)) state_d = pend_q ? B_LK_RD : B_IDLE;
      B_IDLE: begin
        if (!q_empty_i) begin
          state_d = (q_item_i.first_of_batch && wrap) ? B_CLEAR : B_LK_RD;
        end
      end
      B_LK_RD: state_d = B_LK_CHK;
      B_LK_CHK: begin
        if (!rd_live || lk_eq || n_last) state_d = B_BUF;
        else state_d = B_LK_RD;
      end
      B_BUF: begin
        if (!item_q.last_in_group) state_d = B_IDLE;
        else if (conflict_q) state_d = B_EM_RD;
        else state_d = B_IN_RD;
      end
      B_IN_RD: state_d = B_IN_LD;
      B_IN_LD: state_d = B_IN_PR;
      B_IN_PR: state_d = B_IN_CHK;
      B_IN_CHK: begin
        if (!rd_live || in_eq || n_last) state_d = k_last ? B_EM_RD : B_IN_RD;
        else state_d = B_IN_PR;
      end
      B_EM_RD: state_d = B_EM_OUT;
      B_EM_OUT: if (out_free) state_d = k_last ? B_IDLE : B_EM_RD;
      default: state_d = B_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    epoch_d    = epoch_q;
    clr_d      = clr_q;
    pend_d     = pend_q;
    probe_d    = probe_q;
    n_d        = n_q;
    fill_d     = fill_q;
    k_d        = k_q;
    conflict_d = conflict_q;
    ovf_d      = ovf_q;
    item_d     = item_q;
    slot_d     = slot_q;
    ins_node_d = ins_node_q;
    out_d      = out_q;
    out_valid_d = out_valid_q && !pop_i;
    q_pop_o    = 1'b0;
    set_we     = 1'b0;
    set_wa     = probe_q;
    set_wd     = {epoch_q, ins_node_q};
    buf_we     = 1'b0;
    unique case (state_q)
      B_CLEAR: begin
        set_we = 1'b1;
        set_wa = clr_q;
        set_wd = '0;
        clr_d  = clr_q + SW'(1);
        if (clr_q == SW'(SET_DEPTH - 1)) begin
          epoch_d = EPOCH_W'(1);
          pend_d  = 1'b0;
        end
      end
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          slot_d  = q_slot_i;
          probe_d = q_slot_i;
          n_d     = '0;
          if (q_item_i.first_of_batch) begin
            // a new epoch empties the set; wrap needs a real clearing pass
            epoch_d = epoch_inc;
            clr_d   = '0;
            pend_d  = wrap;
          end
        end
      end
      B_LK_RD: ;
      B_LK_CHK: begin
        if (rd_live && lk_eq) conflict_d = 1'b1;
        probe_d = probe_nxt;
        n_d     = n_inc;
      end
      B_BUF: begin
        if (fill_ok) begin
          buf_we = 1'b1;
          fill_d = fill_q + FW'(1);
        end else begin
          ovf_d = 1'b1;
        end
        k_d = '0;
      end
      B_IN_RD: ;
      B_IN_LD: begin
        ins_node_d = buf_node;
        probe_d    = buf_slot;
        n_d        = '0;
      end
      B_IN_PR: ;
      B_IN_CHK: begin
        probe_d = probe_nxt;
        n_d     = n_inc;
        if (!rd_live) begin
          set_we = 1'b1;
        end else if (!in_eq && n_last) begin
          ovf_d = 1'b1;
        end
        if (!rd_live || in_eq || n_last) k_d = k_last ? '0 : k_inc;
      end
      B_EM_RD: ;
      B_EM_OUT: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.out_node     = conflict_q ? '1 : buf_node;
          out_d.out_gain     = buf_gain;
          out_d.accepted     = !conflict_q;
          out_d.group_end    = k_last;
          out_d.overflow     = ovf_q;
          if (k_last) begin
            fill_d     = '0;
            k_d        = '0;
            conflict_d = 1'b0;
            ovf_d      = 1'b0;
          end else begin
            k_d = k_inc;
          end
        end
      end
      default: ;
    endcase
  end

  assign clear_busy_o = (state_q == B_CLEAR);
  assign empty_o      = !out_valid_q;
  assign out_item_o   = out_q;

  always_ff @(posedge clk_i) begin
    if (set_we) set_mem[set_wa] <= set_wd;
    set_rd_q <= set_mem[probe_q];
  end

  always_ff @(posedge clk_i) begin
    if (buf_we) buf_mem[fill_q[GW-1:0]] <= {item_q.node_id, item_q.move_gain, slot_q};
    buf_rd_q <= buf_mem[k_q[GW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      epoch_q     <= EPOCH_W'(1);
      clr_q       <= '0;
      pend_q      <= 1'b0;
      probe_q     <= '0;
      n_q         <= '0;
      fill_q      <= '0;
      k_q         <= '0;
      conflict_q  <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      epoch_q     <= epoch_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      probe_q     <= probe_d;
      n_q         <= n_d;
      fill_q      <= fill_d;
      k_q         <= k_d;
      conflict_q  <= conflict_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    slot_q     <= slot_d;
    ins_node_q <= ins_node_d;
    out_q      <= out_d;
  end

endmodule
`default_nettype wire

### hdl/move_group_conflict_resolver_core.sv
// front: one move at a time; full stays high until it is handed off (hash multiply, sum,
// reciprocal multiply, quotient, remainder, hand-off), which waits on a full queue
// back: per move a pop, lookup read and check, buffer write; each extra probe adds a lookup
// group end: unless the group conflicted, each buffered move is inserted into the set (each
// extra probe adds a lookup), then each result is read from the buffer and emitted in turn
// reset: clearing all SET_DEPTH slots holds full high; reruns every 255th batch start
// ---------------------------------------------------------------------------
// move_group_conflict_resolver_core
// greedy resolver that accepts or rejects whole groups of node moves
// ---------------------------------------------------------------------------
`default_nettype none
module move_group_conflict_resolver_core #(
  parameter int unsigned SET_DEPTH = 1024,
  parameter int unsigned MAX_GROUP = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  mgcr_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output mgcr_pkg::out_item_t out_item_o
);
  import mgcr_pkg::*;

  localparam int unsigned SW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int unsigned QW = $bits(in_item_t) + SW;

  logic          front_busy, clear_busy;
  logic          q_push, q_full, q_pop, q_empty;
  in_item_t      f_item;
  logic [SW-1:0] f_slot;
  logic [QW-1:0] q_dout;

  assign full = front_busy || clear_busy;

  mgcr_front #(
    .SET_DEPTH (SET_DEPTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push && !full),
    .busy_o    (front_busy),
    .in_item_i (in_item_i),
    .q_push_o  (q_push),
    .q_full_i  (q_full),
    .q_item_o  (f_item),
    .q_slot_o  (f_slot)
  );

  mgcr_queue #(
    .DW    (QW),
    .DEPTH (2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  ({f_item, f_slot}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_dout),
    .empty_o (q_empty)
  );

  mgcr_back #(
    .SET_DEPTH (SET_DEPTH),
    .MAX_GROUP (MAX_GROUP)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .q_item_i     (in_item_t'(q_dout[QW-1:SW])),
    .q_slot_i     (q_dout[SW-1:0]),
    .clear_busy_o (clear_busy),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_item_o   (out_item_o)
  );

endmodule
`default_nettype wire

### hdl/mgcr_checker.sv
// ---------------------------------------------------------------------------
// mgcr_checker
// port-level checks on the resolver's result side and reset behavior
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module mgcr_checker (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                full,
  input  wire logic                empty,
  input  wire logic                pop,
  input  wire mgcr_pkg::out_item_t out_item_o
);

  // a rejected move always carries the all-ones node
  `MGCR_ASSERT_NOW(a_reject_node, clk_i, rst_ni, !empty && !out_item_o.accepted, out_item_o.out_node == 64'hFFFF_FFFF_FFFF_FFFF, "rejected move without all-ones node")

  // the set is being cleared right after reset, so no transfer is taken
  `MGCR_ASSERT_NOW(a_reset_full, clk_i, rst_ni, $rose(rst_ni), full, "input open during clearing pass")

  // a waiting result holds until popped
  `MGCR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(out_item_o), "result changed while stalled")

endmodule

bind move_group_conflict_resolver_core mgcr_checker u_checker (.*);
`default_nettype wire

### sim/move_group_conflict_resolver_core_test.sv
// ---------------------------------------------------------------------------
// move_group_conflict_resolver_core_test
// drives grouped node moves through the queue-style ports and checks every
// emitted move against a predictor that keeps its own moved-node hash set
// ---------------------------------------------------------------------------
`default_nettype none
module move_group_conflict_resolver_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mgcr_pkg::*;

  localparam int unsigned SET_DEPTH  = 1024;
  localparam int unsigned MAX_GROUP  = 16;
  localparam int unsigned IDLE_LIMIT = 200000;
  localparam logic [63:0] NODE_NONE  = '1;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  logic      full;
  logic      empty;
  in_item_t  in_item_i = '0;
  out_item_t out_item_o;

  move_group_conflict_resolver_core #(
    .SET_DEPTH(SET_DEPTH),
    .MAX_GROUP(MAX_GROUP)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push(push),
    .full(full),
    .in_item_i(in_item_i),
    .empty(empty),
    .pop(pop),
    .out_item_o(out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [63:0]        moved_keys [SET_DEPTH];
  bit                 moved_valid [SET_DEPTH];
  logic [63:0]        grp_nodes [MAX_GROUP];
  logic signed [31:0] grp_gains [MAX_GROUP];
  int unsigned        grp_fill = 0;
  bit                 grp_conflict = 0;
  bit                 grp_overflow = 0;
  out_item_t          expected_moves [$];

  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          timed_out = 0;

  function automatic int unsigned home_slot(logic [63:0] key);
    logic [63:0] h;
    h = key * HASH_MULT;
    return h[63:32] % SET_DEPTH;
  endfunction

  function automatic bit is_moved(logic [63:0] key);
    int unsigned s;
    s = home_slot(key);
    for (int n = 0; n < SET_DEPTH; n++) begin
      if (!moved_valid[s]) return 0;
      if (moved_keys[s] == key) return 1;
      s = (s + 1) % SET_DEPTH;
    end
    return 0;
  endfunction

  function automatic bit mark_moved(logic [63:0] key);
    int unsigned s;
    s = home_slot(key);
    for (int n = 0; n < SET_DEPTH; n++) begin
      if (!moved_valid[s]) begin
        moved_valid[s] = 1;
        moved_keys[s] = key;
        return 1;
      end
      if (moved_keys[s] == key) return 1;
      s = (s + 1) % SET_DEPTH;
    end
    return 0;
  endfunction

  task automatic resolve_move(in_item_t mv);
    out_item_t r;
    if (mv.first_of_batch) begin
      foreach (moved_valid[i]) moved_valid[i] = 0;
    end
    if (is_moved(mv.node_id)) grp_conflict = 1;
    if (grp_fill < MAX_GROUP) begin
      grp_nodes[grp_fill] = mv.node_id;
      grp_gains[grp_fill] = mv.move_gain;
      grp_fill++;
    end else begin
      grp_overflow = 1;
    end
    if (mv.last_in_group) begin
      if (!grp_conflict) begin
        for (int k = 0; k < grp_fill; k++)
          if (!mark_moved(grp_nodes[k])) grp_overflow = 1;
      end
      for (int k = 0; k < grp_fill; k++) begin
        r.out_node  = grp_conflict ? NODE_NONE : grp_nodes[k];
        r.out_gain  = grp_gains[k];
        r.accepted  = !grp_conflict;
        r.group_end = (k + 1 == grp_fill);
        r.overflow  = grp_overflow;
        expected_moves.push_back(r);
      end
      grp_fill = 0;
      grp_conflict = 0;
      grp_overflow = 0;
    end
  endtask

  function automatic in_item_t move_of(logic [63:0] node, logic [31:0] gain,
                                       bit last, bit first);
    in_item_t mv;
    mv.node_id = node;
    mv.move_gain = gain;
    mv.last_in_group = last;
    mv.first_of_batch = first;
    return mv;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  bit no_gaps = 0;

  task automatic send_move(in_item_t mv);
    int unsigned gap;
    gap = no_gaps ? 0 : gap_len();
    if (gap > 0) begin
      @(negedge clk_i);
      push = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push = 1'b1;
    in_item_i = mv;
    do @(posedge clk_i); while (full);
    resolve_move(mv);
  endtask

  // result side: random stalls, some stretches with pop held high
  int unsigned stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      pop = 1'b0;
    end else if ($urandom_range(0, 99) < 12) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                               : $urandom_range(1, 3);
      pop = 1'b0;
    end else begin
      pop = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_moves.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: node %h gain %0d acc %b end %b ovf %b",
                   out_item_o.out_node, out_item_o.out_gain, out_item_o.accepted,
                   out_item_o.group_end, out_item_o.overflow);
      end else begin
        if (out_item_o !== expected_moves[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp node %h gain %0d acc %b end %b ovf %b / got node %h gain %0d acc %b end %b ovf %b",
                     expected_moves[0].out_node, expected_moves[0].out_gain,
                     expected_moves[0].accepted, expected_moves[0].group_end,
                     expected_moves[0].overflow, out_item_o.out_node,
                     out_item_o.out_gain, out_item_o.accepted,
                     out_item_o.group_end, out_item_o.overflow);
        end
        void'(expected_moves.pop_front());
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic test_single_moves();
    send_move(move_of(64'd0, 32'h8000_0000, 1, 1));
    send_move(move_of(64'hFFFF_FFFF_FFFF_FFFE, 32'h7FFF_FFFF, 1, 0));
    send_move(move_of(NODE_NONE, 32'd0, 1, 0));          // all-ones key, accepted
    send_move(move_of(64'd0, 32'hFFFF_FFFF, 1, 0));      // conflicts with first move
  endtask

  task automatic test_group_conflicts();
    // repeats inside a group are fine
    send_move(move_of(64'd10, 32'd1, 0, 0));
    send_move(move_of(64'd10, 32'd2, 0, 0));
    send_move(move_of(64'd11, 32'd3, 1, 0));
    // one old node rejects the whole group
    send_move(move_of(64'd12, 32'd4, 0, 0));
    send_move(move_of(64'd11, 32'd5, 0, 0));
    send_move(move_of(64'd13, 32'd6, 1, 0));
    send_move(move_of(64'd12, 32'd7, 1, 0));
  endtask

  task automatic test_buffer_overflow();
    // the dropped tail move still finds node 10
    for (int i = 0; i < MAX_GROUP; i++)
      send_move(move_of(64'd100 + i, $urandom, 0, 0));
    send_move(move_of(64'd10, $urandom, 1, 0));
    for (int i = 0; i < MAX_GROUP + 2; i++)
      send_move(move_of(64'd200 + i, $urandom, i == MAX_GROUP + 1, 0));
  endtask

  task automatic test_batch_restart();
    // batch start mid-group keeps the buffered moves
    send_move(move_of(64'd300, 32'd9, 0, 0));
    send_move(move_of(64'd10, 32'd8, 1, 1));
    send_move(move_of(64'd300, 32'd7, 1, 0));
  endtask

  task automatic test_random_groups();
    logic [63:0] node;
    int unsigned len;
    int unsigned sent;
    sent = 0;
    while (sent < 130) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(MAX_GROUP - 1, MAX_GROUP + 3)
                                         : $urandom_range(1, 6);
      no_gaps = ($urandom_range(0, 5) == 0);
      for (int i = 0; i < len; i++) begin
        node = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                           : 64'($urandom_range(0, 40));
        send_move(move_of(node, $urandom, i == len - 1,
                          $urandom_range(0, 24) == 0));
        sent++;
      end
    end
    no_gaps = 0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_single_moves();
    test_group_conflicts();
    test_buffer_overflow();
    test_batch_restart();
    test_random_groups();
    @(negedge clk_i);
    push = 1'b0;
    while (expected_moves.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && expected_moves.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
